### rtl/core/life_grid_generation_engine_macros.svh
// ----------------------------------------------------------------------------
// Life grid engine assertion macros
// Clocked assertion shorthands shared by the engine RTL.
// ----------------------------------------------------------------------------
`ifndef LIFE_GRID_GENERATION_ENGINE_MACROS_SVH
`define LIFE_GRID_GENERATION_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LGE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LGE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/lge_pkg.sv
// ----------------------------------------------------------------------------
// Life grid engine package
// Shared types, constants and the B3/S23 cell rule.
// ----------------------------------------------------------------------------
package lge_pkg;

	localparam int GRID_DIM_DEF = 64;
	localparam int IDX_W        = 6;

	localparam logic [3:0] LIVE_MIN  = 4'd2;
	localparam logic [3:0] BIRTH_CNT = 4'd3;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_TOGGLE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_STEP   = 2'd3
	} lge_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CELL,
		ST_SWEEP
	} lge_state_t;

	typedef struct packed {
		logic clr;
		logic rd_en;
		logic wr_en;
	} lge_mem_ctl_t;

	// Next state of one cell from its own state and its eight neighbors.
	function automatic logic life_next(input logic alive, input logic [7:0] nb);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + 4'(nb[i]);
		end
		if (alive) begin
			return (n == LIVE_MIN) || (n == BIRTH_CNT);
		end
		return n == BIRTH_CNT;
	endfunction

endpackage

### rtl/core/lge_grid_mem.sv
// ----------------------------------------------------------------------------
// Life grid row memory
// One row per word, one write and one registered read port, row valid bits.
// ----------------------------------------------------------------------------
module lge_grid_mem #(
	parameter int GRID_DIM = lge_pkg::GRID_DIM_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lge_pkg::lge_mem_ctl_t       ctl,
	input  logic [$clog2(GRID_DIM)-1:0] rd_addr,
	input  logic [$clog2(GRID_DIM)-1:0] wr_addr,
	input  logic [GRID_DIM-1:0]         wr_data,
	output logic [GRID_DIM-1:0]         rd_data
);

	logic [GRID_DIM-1:0] mem [GRID_DIM];
	logic [GRID_DIM-1:0] row_vld_q;
	logic [GRID_DIM-1:0] rd_q;
	logic                rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// A row never written since reset or the last clear reads as dead.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (ctl.clr) begin
				row_vld_q <= '0;
			end else if (ctl.wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_vld_q <= row_vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

### rtl/core/lge_row_rule.sv
// ----------------------------------------------------------------------------
// Life grid row rule unit
// Next generation of one row from the three-row window; border columns die.
// ----------------------------------------------------------------------------
module lge_row_rule #(
	parameter int GRID_DIM = lge_pkg::GRID_DIM_DEF
) (
	input  logic [GRID_DIM-1:0] above,
	input  logic [GRID_DIM-1:0] cur,
	input  logic [GRID_DIM-1:0] below,
	output logic [GRID_DIM-1:0] nxt
);

	for (genvar c = 0; c < GRID_DIM; c++) begin : g_col
		if (c == 0 || c == GRID_DIM - 1) begin : g_edge
			assign nxt[c] = 1'b0;
		end else begin : g_inner
			assign nxt[c] = lge_pkg::life_next(cur[c], {
				above[c-1], above[c], above[c+1],
				cur[c-1], cur[c+1],
				below[c-1], below[c], below[c+1]
			});
		end
	end

endmodule

### rtl/core/life_grid_generation_engine.sv
// ----------------------------------------------------------------------------
// Life grid generation engine
// Square B3/S23 life grid with clear, toggle, read and advance commands.
// ----------------------------------------------------------------------------
// A word is accepted when start is high and busy is low, and every word
// returns exactly one result word, shown for one cycle with done high; the
// receiver cannot stall it, so capture cell_alive whenever done is high.
// Clear, and toggle or read at an address outside the grid, answer with
// done in the cycle after the accept while busy stays low. Toggle and read
// inside the grid go through the registered row read, then the CELL state,
// which picks the cell and, for a toggle, writes the row back. An advance is
// a busy sweep that reads one row per cycle from the single row memory and
// writes one new row per cycle through the row rule unit, with the top and
// bottom rows written dead, then shows done. Clear is immediate through
// per-row valid bits, so the grid needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "life_grid_generation_engine_macros.svh"

module life_grid_generation_engine #(
	parameter int GRID_DIM = lge_pkg::GRID_DIM_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                command,
	input  logic [lge_pkg::IDX_W-1:0] row,
	input  logic [lge_pkg::IDX_W-1:0] col,
	output logic                      done,
	output logic                      cell_alive
);

	localparam int AW = $clog2(GRID_DIM);
	localparam int CW = $clog2(GRID_DIM + 2);
	localparam logic [GRID_DIM-1:0] ONE_ROW = GRID_DIM'(1);

	lge_pkg::lge_state_t   state_q, state_d;
	lge_pkg::lge_cmd_t     cmd_in, cmd_q;
	lge_pkg::lge_mem_ctl_t mem_ctl;

	logic [AW-1:0]       row_q, col_q;
	logic [CW-1:0]       cnt_q, cnt_d, wr_row;
	logic [GRID_DIM-1:0] prev_q, cur_q;
	logic [GRID_DIM-1:0] rd_data, wr_data, rule_row;
	logic [AW-1:0]       rd_addr, wr_addr;
	logic [31:0]         row_ext, col_ext;
	logic                in_grid, accept, shift;
	logic                done_q, done_d, alive_q, alive_d;
	logic                cell_bit;

	assign cmd_in  = lge_pkg::lge_cmd_t'(command);
	assign row_ext = 32'(row);
	assign col_ext = 32'(col);
	assign in_grid = (row_ext < 32'(GRID_DIM)) && (col_ext < 32'(GRID_DIM));
	assign busy    = state_q != lge_pkg::ST_IDLE;
	assign accept  = start && !busy;
	assign wr_row  = cnt_q - CW'(2);
	assign cell_bit = rd_data[col_q];

	lge_grid_mem #(
		.GRID_DIM (GRID_DIM)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mem_ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	// Window: prev_q holds the row above, cur_q the row itself, and the
	// memory output the row below, as it arrives during the sweep.
	lge_row_rule #(
		.GRID_DIM (GRID_DIM)
	) u_rule (
		.above (prev_q),
		.cur   (cur_q),
		.below (rd_data),
		.nxt   (rule_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lge_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mem_ctl = '0;
		rd_addr = '0;
		wr_addr = '0;
		wr_data = '0;
		done_d  = 1'b0;
		alive_d = 1'b0;
		shift   = 1'b0;
		cnt_d   = cnt_q;
		unique case (state_q)
			lge_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (cmd_in) inside
						lge_pkg::CMD_CLEAR: begin
							// Drop every row at once through the valid bits.
							mem_ctl.clr = 1'b1;
							done_d      = 1'b1;
						end
						lge_pkg::CMD_TOGGLE, lge_pkg::CMD_READ: begin
							if (in_grid) begin
								mem_ctl.rd_en = 1'b1;
								rd_addr       = row_ext[AW-1:0];
								state_d       = lge_pkg::ST_CELL;
							end else begin
								// Outside the grid: nothing changes, answer dead.
								done_d = 1'b1;
							end
						end
						lge_pkg::CMD_STEP: begin
							cnt_d   = '0;
							state_d = lge_pkg::ST_SWEEP;
						end
						default: begin
							state_d = lge_pkg::ST_IDLE;
						end
					endcase
				end
			end
			lge_pkg::ST_CELL: begin
				done_d  = 1'b1;
				state_d = lge_pkg::ST_IDLE;
				if (cmd_q == lge_pkg::CMD_TOGGLE) begin
					mem_ctl.wr_en = 1'b1;
					wr_addr       = row_q;
					wr_data       = rd_data ^ (ONE_ROW << col_q);
					alive_d       = !cell_bit;
				end else begin
					alive_d = cell_bit;
				end
			end
			lge_pkg::ST_SWEEP: begin
				// Read row cnt, take in row cnt-1, write new row cnt-2.
				cnt_d = cnt_q + CW'(1);
				if (cnt_q < CW'(GRID_DIM)) begin
					mem_ctl.rd_en = 1'b1;
					rd_addr       = cnt_q[AW-1:0];
				end
				if (cnt_q != '0 && cnt_q <= CW'(GRID_DIM)) begin
					shift = 1'b1;
				end
				if (cnt_q >= CW'(2)) begin
					mem_ctl.wr_en = 1'b1;
					wr_addr       = wr_row[AW-1:0];
					// Top and bottom rows of the new grid are dead.
					if (cnt_q == CW'(2) || cnt_q == CW'(GRID_DIM + 1)) begin
						wr_data = '0;
					end else begin
						wr_data = rule_row;
					end
				end
				if (cnt_q == CW'(GRID_DIM + 1)) begin
					done_d  = 1'b1;
					state_d = lge_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lge_pkg::ST_IDLE;
			end
		endcase
	end

	// Control and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			alive_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q  <= done_d;
			alive_q <= alive_d;
			cnt_q   <= cnt_d;
		end
	end

	// Command capture and row window; payload only.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_in;
			row_q <= row_ext[AW-1:0];
			col_q <= col_ext[AW-1:0];
		end
		if (shift) begin
			prev_q <= cur_q;
			cur_q  <= rd_data;
		end
	end

	assign done       = done_q;
	assign cell_alive = alive_q;

	`LGE_ASSERT_NOW(a_no_rw_collide, clk, arst_n, mem_ctl.rd_en && mem_ctl.wr_en,
		rd_addr != wr_addr, "row read and write hit the same row")
	`LGE_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy,
		"result shown while still busy")
	`LGE_ASSERT_NEXT(a_clear_dead, clk, arst_n, accept && cmd_in == lge_pkg::CMD_CLEAR,
		done && !cell_alive, "clear must answer dead at once")
	`LGE_ASSERT_NOW(a_done_cause, clk, arst_n, done, $past(busy) || $past(start),
		"result with no word behind it")

endmodule

### sim/life_grid_generation_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Life grid generation engine testbench
// Drives clear, toggle, read and advance words into the engine. A local copy
// of the grid predicts each result word and the checker compares it.
// ----------------------------------------------------------------------------
module life_grid_generation_engine_test;

	localparam int GRID_N     = lge_pkg::GRID_DIM_DEF;
	localparam int IDX_W      = lge_pkg::IDX_W;
	localparam int STEP_LAT   = GRID_N + 2;
	localparam int WINDOW     = 8;
	localparam int NOISE_WORDS = 100;

	// One expected result word, with the command that caused it for messages.
	typedef struct {
		lge_pkg::lge_cmd_t cmd;
		logic [IDX_W-1:0]  r;
		logic [IDX_W-1:0]  c;
		logic              alive;
	} cell_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [1:0]       command = 2'd0;
	logic [IDX_W-1:0] row = '0;
	logic [IDX_W-1:0] col = '0;
	logic             busy;
	logic             done;
	logic             cell_alive;

	// Local copy of the grid, updated as each word is accepted.
	logic [GRID_N-1:0] shadow_grid [GRID_N];
	cell_result_t      pending_cells[$];
	int                error_count = 0;
	bit                no_idle = 1'b0;

	life_grid_generation_engine #(
		.GRID_DIM(GRID_N)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.row(row),
		.col(col),
		.done(done),
		.cell_alive(cell_alive)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		error_count++;
	endtask

	// Advance the shadow grid by one B3/S23 generation; the border ends up dead.
	function automatic void shadow_advance();
		logic [GRID_N-1:0] next_grid [GRID_N];
		int                nbrs;
		for (int r = 0; r < GRID_N; r++) begin
			next_grid[r] = '0;
		end
		for (int r = 1; r < GRID_N - 1; r++) begin
			for (int c = 1; c < GRID_N - 1; c++) begin
				nbrs = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						if (dr != 0 || dc != 0) begin
							nbrs += int'(shadow_grid[r + dr][c + dc]);
						end
					end
				end
				next_grid[r][c] = (nbrs == 3) || (shadow_grid[r][c] && nbrs == 2);
			end
		end
		for (int r = 0; r < GRID_N; r++) begin
			shadow_grid[r] = next_grid[r];
		end
	endfunction

	// Apply one command to the shadow grid and return the cell state it reports.
	function automatic logic shadow_apply(input lge_pkg::lge_cmd_t cmd, input int r,
		input int c);
		logic on_grid;
		on_grid = (r < GRID_N) && (c < GRID_N);
		case (cmd)
			lge_pkg::CMD_CLEAR: begin
				for (int i = 0; i < GRID_N; i++) begin
					shadow_grid[i] = '0;
				end
				return 1'b0;
			end
			lge_pkg::CMD_TOGGLE: begin
				if (!on_grid) begin
					return 1'b0;
				end
				shadow_grid[r][c] = ~shadow_grid[r][c];
				return shadow_grid[r][c];
			end
			lge_pkg::CMD_READ: begin
				return on_grid ? shadow_grid[r][c] : 1'b0;
			end
			default: begin
				shadow_advance();
				return 1'b0;
			end
		endcase
	endfunction

	// Send one word. On return we sit at the accepting edge with start still
	// high, so the next call either lowers it or replaces the fields in the
	// same time step: the engine never sees the old word twice.
	task automatic send_word(input lge_pkg::lge_cmd_t cmd, input int r, input int c);
		cell_result_t exp_cell;
		int           gap;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		repeat (gap) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		command <= cmd;
		row     <= IDX_W'(r);
		col     <= IDX_W'(c);
		@(posedge clk);
		// busy read here is the value from before the edge
		while (busy) begin
			@(posedge clk);
		end
		exp_cell.cmd   = cmd;
		exp_cell.r     = IDX_W'(r);
		exp_cell.c     = IDX_W'(c);
		exp_cell.alive = shadow_apply(cmd, r, c);
		pending_cells.push_back(exp_cell);
	endtask

	// Hold the sender off until every outstanding result word is back.
	task automatic drain_results();
		start <= 1'b0;
		while (pending_cells.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Check each result word against the oldest expectation. The receiver
	// cannot stall, so capture on every edge where done was high.
	always @(posedge clk) begin
		cell_result_t exp_cell;
		if (arst_n && done) begin
			if (pending_cells.size() == 0) begin
				report_mismatch($sformatf("result word with nothing pending, cell_alive=%0b",
					cell_alive));
			end else begin
				exp_cell = pending_cells.pop_front();
				if (cell_alive !== exp_cell.alive) begin
					report_mismatch($sformatf("%s row %0d col %0d: cell_alive=%b, want %b",
						exp_cell.cmd.name(), exp_cell.r, exp_cell.c, cell_alive,
						exp_cell.alive));
				end
			end
		end
	end

	// Corners, toggle back and forth, border death on advance, a blinker in
	// both phases, and ignored address bits on clear and advance.
	task automatic test_directed();
		no_idle = 1'b0;
		send_word(lge_pkg::CMD_CLEAR, GRID_N - 1, GRID_N - 1);
		send_word(lge_pkg::CMD_READ, 0, 0);
		send_word(lge_pkg::CMD_TOGGLE, 0, 0);
		send_word(lge_pkg::CMD_READ, 0, 0);
		send_word(lge_pkg::CMD_TOGGLE, GRID_N - 1, GRID_N - 1);
		send_word(lge_pkg::CMD_TOGGLE, 0, GRID_N - 1);
		send_word(lge_pkg::CMD_TOGGLE, GRID_N - 1, 0);
		send_word(lge_pkg::CMD_READ, GRID_N - 1, 0);
		send_word(lge_pkg::CMD_TOGGLE, 0, 0);
		send_word(lge_pkg::CMD_TOGGLE, 0, 0);
		send_word(lge_pkg::CMD_TOGGLE, 10, 9);
		send_word(lge_pkg::CMD_TOGGLE, 10, 10);
		send_word(lge_pkg::CMD_TOGGLE, 10, 11);
		send_word(lge_pkg::CMD_STEP, $urandom_range(0, 63), $urandom_range(0, 63));
		send_word(lge_pkg::CMD_READ, 9, 10);
		send_word(lge_pkg::CMD_READ, 10, 9);
		send_word(lge_pkg::CMD_READ, 0, 0);
		send_word(lge_pkg::CMD_READ, GRID_N - 1, GRID_N - 1);
		send_word(lge_pkg::CMD_STEP, GRID_N - 1, 0);
		send_word(lge_pkg::CMD_READ, 10, 11);
		send_word(lge_pkg::CMD_READ, 11, 10);
		send_word(lge_pkg::CMD_CLEAR, 42, 21);
		send_word(lge_pkg::CMD_READ, 10, 10);
	endtask

	// Seed a small window with random live cells, advance a few generations
	// and read back around it. Windows reach the border too.
	task automatic test_patterns(input int n_seeds);
		int r0;
		int c0;
		for (int s = 0; s < n_seeds; s++) begin
			no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1) == 1) begin
				send_word(lge_pkg::CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
			end
			r0 = $urandom_range(0, GRID_N - WINDOW);
			c0 = $urandom_range(0, GRID_N - WINDOW);
			repeat ($urandom_range(6, 20)) begin
				send_word(lge_pkg::CMD_TOGGLE, r0 + $urandom_range(0, WINDOW - 1),
					c0 + $urandom_range(0, WINDOW - 1));
			end
			repeat ($urandom_range(1, 4)) begin
				send_word(lge_pkg::CMD_STEP, $urandom_range(0, 63), $urandom_range(0, 63));
				// hold off once in a while so reads start on an empty pipe
				if (s % 6 == 3) begin
					drain_results();
				end
				repeat ($urandom_range(2, 6)) begin
					send_word(lge_pkg::CMD_READ, r0 + $urandom_range(0, WINDOW - 1),
						c0 + $urandom_range(0, WINDOW - 1));
				end
			end
		end
	endtask

	// Unshaped words over the whole grid, mostly toggles and reads.
	task automatic test_noise(input int n_words);
		int                pick;
		lge_pkg::lge_cmd_t cmd;
		for (int i = 0; i < n_words; i++) begin
			if (i % 25 == 0) begin
				no_idle = ~no_idle;
			end
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				cmd = lge_pkg::CMD_CLEAR;
			end else if (pick < 45) begin
				cmd = lge_pkg::CMD_TOGGLE;
			end else if (pick < 85) begin
				cmd = lge_pkg::CMD_READ;
			end else begin
				cmd = lge_pkg::CMD_STEP;
			end
			send_word(cmd, $urandom_range(0, 63), $urandom_range(0, 63));
		end
	endtask

	initial begin
		int wait_cycles;
		for (int r = 0; r < GRID_N; r++) begin
			shadow_grid[r] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_patterns(16);
		test_noise(NOISE_WORDS);

		// Drop start, let the last results come back, then watch for strays.
		start <= 1'b0;
		wait_cycles = 0;
		while (pending_cells.size() != 0 && wait_cycles < 4 * STEP_LAT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (STEP_LAT + 8) @(posedge clk);
		while (pending_cells.size() != 0) begin
			report_mismatch($sformatf("no result for %s row %0d col %0d",
				pending_cells[0].cmd.name(), pending_cells[0].r, pending_cells[0].c));
			void'(pending_cells.pop_front());
		end

		if (error_count == 0) begin
			$display("life_grid_generation_engine_test: done, clean");
		end else begin
			$display("life_grid_generation_engine_test: done, errors");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("life_grid_generation_engine_test: done, errors");
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/lge_pkg.sv
rtl/core/lge_grid_mem.sv
rtl/core/lge_row_rule.sv
rtl/core/life_grid_generation_engine.sv
sim/life_grid_generation_engine_test.sv
